// ===== rtl/psalu_pkg.sv =====
package psalu_pkg;

    localparam int unsigned C_VEC_W   = 128;
    localparam int unsigned C_HALF_W  = 64;
    localparam int unsigned C_BYTES   = C_VEC_W / 8;
    localparam int unsigned C_WORDS   = C_VEC_W / 16;
    localparam int unsigned C_OP_W    = 4;
    localparam int unsigned C_IMM_W   = 5;
    localparam int unsigned C_SCIN_W  = 32;
    localparam int unsigned C_SCOUT_W = 16;

    typedef enum logic [C_OP_W-1:0] {
        OP_ADDSW    = 4'd0,
        OP_ADDUSB   = 4'd1,
        OP_CMPEQB   = 4'd2,
        OP_CMPGTW   = 4'd3,
        OP_EXTRACTW = 4'd4,
        OP_MAXSW    = 4'd5,
        OP_MAXUB    = 4'd6,
        OP_MOVEMASK = 4'd7,
        OP_SET1W    = 4'd8,
        OP_SET1D    = 4'd9,
        OP_SET1B    = 4'd10,
        OP_SHLB     = 4'd11,
        OP_SHRB     = 4'd12,
        OP_SUBUSW   = 4'd13,
        OP_SUBUSB   = 4'd14
    } t_op;

endpackage

// ===== rtl/packed_integer_simd_alu.sv =====
// An accepted item (start & !busy) passes the input register, then the result register, which drives o_strobe.
// Throughput: 1 item per cycle; the input register and the result register
// form a two-stage pipeline around one pass of lane logic.
// Reset: synchronous, active low; clears the stage valid flags, busy is high
// during reset and the cycle after. Results cannot be stalled by the receiver.
module packed_integer_simd_alu
    import psalu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [C_OP_W-1:0]     i_op,
    input  logic [C_HALF_W-1:0]   i_a_low,
    input  logic [C_HALF_W-1:0]   i_a_high,
    input  logic [C_HALF_W-1:0]   i_b_low,
    input  logic [C_HALF_W-1:0]   i_b_high,
    input  logic [C_IMM_W-1:0]    i_imm,
    input  logic [C_SCIN_W-1:0]   i_scalar_in,
    output logic                  o_strobe,
    output logic [C_HALF_W-1:0]   o_r_low,
    output logic [C_HALF_W-1:0]   o_r_high,
    output logic [C_SCOUT_W-1:0]  o_scalar_out
);

    // ready flag comes up in the cycle after reset is released
    logic                  r_ready;

    // stage 1: input register
    logic                  r_v1;
    logic [C_OP_W-1:0]     r_op;
    logic [C_VEC_W-1:0]    r_a;
    logic [C_VEC_W-1:0]    r_b;
    logic [C_IMM_W-1:0]    r_imm;
    logic [C_SCIN_W-1:0]   r_scalar;

    // stage 2: result register
    logic                  r_v2;
    logic [C_VEC_W-1:0]    r_res;
    logic [C_SCOUT_W-1:0]  r_sc;

    logic [C_VEC_W-1:0]    n_res;
    logic [C_SCOUT_W-1:0]  n_sc;

    logic                  w_accept;

    assign busy     = ~r_ready | ~i_rst_n;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_v1    <= w_accept;
            r_v2    <= r_v1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_a      <= {i_a_high, i_a_low};
            r_b      <= {i_b_high, i_b_low};
            r_imm    <= i_imm;
            r_scalar <= i_scalar_in;
        end
        if (r_v1) begin
            r_res <= n_res;
            r_sc  <= n_sc;
        end
    end

    // lane logic: one pass per item; the byte shifts, extract and movemask work across lanes
    always_comb begin
        logic [16:0] v_s17;
        logic [8:0]  v_u9;
        logic [15:0] v_x16;
        logic [15:0] v_y16;
        logic [7:0]  v_x8;
        logic [7:0]  v_y8;

        n_res = '0;
        n_sc  = '0;
        v_s17 = '0;
        v_u9  = '0;
        v_x16 = '0;
        v_y16 = '0;
        v_x8  = '0;
        v_y8  = '0;

        unique case (r_op)
            OP_ADDSW: begin
                for (int k = 0; k < C_WORDS; k++) begin
                    v_x16 = r_a[k*16 +: 16];
                    v_y16 = r_b[k*16 +: 16];
                    v_s17 = {v_x16[15], v_x16} + {v_y16[15], v_y16};
                    // overflow when the two top bits of the 17-bit sum differ
                    if (v_s17[16] != v_s17[15]) begin
                        n_res[k*16 +: 16] = v_s17[16] ? 16'h8000 : 16'h7FFF;
                    end else begin
                        n_res[k*16 +: 16] = v_s17[15:0];
                    end
                end
            end
            OP_ADDUSB: begin
                for (int k = 0; k < C_BYTES; k++) begin
                    v_u9 = {1'b0, r_a[k*8 +: 8]} + {1'b0, r_b[k*8 +: 8]};
                    n_res[k*8 +: 8] = v_u9[8] ? 8'hFF : v_u9[7:0];
                end
            end
            OP_CMPEQB: begin
                for (int k = 0; k < C_BYTES; k++) begin
                    n_res[k*8 +: 8] = (r_a[k*8 +: 8] == r_b[k*8 +: 8]) ? 8'hFF : 8'h00;
                end
            end
            OP_CMPGTW: begin
                for (int k = 0; k < C_WORDS; k++) begin
                    n_res[k*16 +: 16] =
                        ($signed(r_a[k*16 +: 16]) > $signed(r_b[k*16 +: 16])) ?
                        16'hFFFF : 16'h0000;
                end
            end
            OP_EXTRACTW: begin
                // only the low three index bits pick the word
                n_sc = r_a[{r_imm[2:0], 4'b0000} +: 16];
            end
            OP_MAXSW: begin
                for (int k = 0; k < C_WORDS; k++) begin
                    v_x16 = r_a[k*16 +: 16];
                    v_y16 = r_b[k*16 +: 16];
                    n_res[k*16 +: 16] = ($signed(v_x16) > $signed(v_y16)) ? v_x16 : v_y16;
                end
            end
            OP_MAXUB: begin
                for (int k = 0; k < C_BYTES; k++) begin
                    v_x8 = r_a[k*8 +: 8];
                    v_y8 = r_b[k*8 +: 8];
                    n_res[k*8 +: 8] = (v_x8 > v_y8) ? v_x8 : v_y8;
                end
            end
            OP_MOVEMASK: begin
                for (int k = 0; k < C_BYTES; k++) begin
                    n_sc[k] = r_a[k*8 + 7];
                end
            end
            OP_SET1W: begin
                n_res = {C_WORDS{r_scalar[15:0]}};
            end
            OP_SET1D: begin
                n_res = {(C_VEC_W / C_SCIN_W){r_scalar}};
            end
            OP_SET1B: begin
                n_res = {C_BYTES{r_scalar[7:0]}};
            end
            OP_SHLB: begin
                // counts of 16 and above clear the vector
                if (!r_imm[4]) begin
                    n_res = r_a << {r_imm[3:0], 3'b000};
                end
            end
            OP_SHRB: begin
                if (!r_imm[4]) begin
                    n_res = r_a >> {r_imm[3:0], 3'b000};
                end
            end
            OP_SUBUSW: begin
                for (int k = 0; k < C_WORDS; k++) begin
                    v_x16 = r_a[k*16 +: 16];
                    v_y16 = r_b[k*16 +: 16];
                    n_res[k*16 +: 16] = (v_x16 < v_y16) ? 16'h0000 : (v_x16 - v_y16);
                end
            end
            OP_SUBUSB: begin
                for (int k = 0; k < C_BYTES; k++) begin
                    v_x8 = r_a[k*8 +: 8];
                    v_y8 = r_b[k*8 +: 8];
                    n_res[k*8 +: 8] = (v_x8 < v_y8) ? 8'h00 : (v_x8 - v_y8);
                end
            end
            default: begin
                // unused opcode: all-zero result
                n_res = '0;
                n_sc  = '0;
            end
        endcase
    end

    assign o_strobe     = r_v2;
    assign o_r_low      = r_res[C_HALF_W-1:0];
    assign o_r_high     = r_res[C_VEC_W-1:C_HALF_W];
    assign o_scalar_out = r_sc;

    // every accepted item shows up as a strobe after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 o_strobe)
        else $error("accepted item did not produce a result strobe");

    // a strobe always traces back to a stage-1 item
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_v1))
        else $error("result strobe without an item in the input stage");

    // vector operations leave the scalar result at zero
    a_vec_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(r_op) != OP_EXTRACTW && $past(r_op) != OP_MOVEMASK)
        |-> (o_scalar_out == '0))
        else $error("nonzero scalar result for a vector operation");

    // scalar operations leave the vector result at zero
    a_scalar_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(r_op) == OP_EXTRACTW || $past(r_op) == OP_MOVEMASK))
        |-> (o_r_low == '0 && o_r_high == '0))
        else $error("nonzero vector result for a scalar operation");

endmodule

// ===== tb/packed_integer_simd_alu_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the 128-bit packed integer SIMD ALU.
// Items go in on start/busy and come back on o_strobe; the
// block keeps no state, so every accepted item maps to exactly one result.
// An expectation is queued at each accepting edge and popped at each strobe.
module packed_integer_simd_alu_test;
    import psalu_pkg::*;

    localparam real CLK_HALF_NS  = 4.0;
    localparam int  LIMIT_NS     = 600_000;   // far above a clean run
    localparam int  TAIL_CYCLES  = 6;         // pipeline is two deep; a little margin
    localparam int  PHASE_ITEMS  = 234;
    localparam logic [C_OP_W-1:0] OP_UNUSED = 4'hF;  // opcode with no operation

    // One result item: vector halves plus the scalar lane/mask.
    typedef struct packed {
        logic [C_HALF_W-1:0]  r_low;
        logic [C_HALF_W-1:0]  r_high;
        logic [C_SCOUT_W-1:0] sc;
    } t_lane_result;

    // One row of directed stimulus. Rows with fixed set carry their answer.
    typedef struct {
        logic [C_OP_W-1:0]   op;
        logic [C_VEC_W-1:0]  a;
        logic [C_VEC_W-1:0]  b;
        logic [C_IMM_W-1:0]  imm;
        logic [C_SCIN_W-1:0] s;
        bit                  fixed;
        t_lane_result        answer;
    } t_op_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [C_OP_W-1:0]     i_op;
    logic [C_HALF_W-1:0]   i_a_low;
    logic [C_HALF_W-1:0]   i_a_high;
    logic [C_HALF_W-1:0]   i_b_low;
    logic [C_HALF_W-1:0]   i_b_high;
    logic [C_IMM_W-1:0]    i_imm;
    logic [C_SCIN_W-1:0]   i_scalar_in;
    logic                  o_strobe;
    logic [C_HALF_W-1:0]   o_r_low;
    logic [C_HALF_W-1:0]   o_r_high;
    logic [C_SCOUT_W-1:0]  o_scalar_out;

    t_lane_result pending_results[$];   // oldest expectation at the front
    t_op_row      directed_rows[$];
    int           mismatch_count = 0;

    // Typed answer for the item currently on the ports (directed rows only).
    bit           row_fixed = 1'b0;
    t_lane_result row_answer = '0;

    packed_integer_simd_alu u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_a_low      (i_a_low),
        .i_a_high     (i_a_high),
        .i_b_low      (i_b_low),
        .i_b_high     (i_b_high),
        .i_imm        (i_imm),
        .i_scalar_in  (i_scalar_in),
        .o_strobe     (o_strobe),
        .o_r_low      (o_r_low),
        .o_r_high     (o_r_high),
        .o_scalar_out (o_scalar_out)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Lane-by-lane model of the ALU. Lanes are little-endian: byte i is
    // bits 8i+7..8i, word k is bits 16k+15..16k.
    function automatic t_lane_result simd_result(input logic [C_OP_W-1:0] op,
                                                 input logic [C_VEC_W-1:0] a,
                                                 input logic [C_VEC_W-1:0] b,
                                                 input logic [C_IMM_W-1:0] imm,
                                                 input logic [C_SCIN_W-1:0] s);
        t_lane_result         res;
        logic [C_VEC_W-1:0]   r;
        logic [C_SCOUT_W-1:0] sc;
        int                   x;
        int                   y;
        int                   t;
        r  = '0;
        sc = '0;
        case (op)
            OP_ADDSW: begin
                for (int k = 0; k < 8; k++) begin
                    x = $signed(a[16*k +: 16]);
                    y = $signed(b[16*k +: 16]);
                    t = x + y;
                    if (t > 32767)  t = 32767;
                    if (t < -32768) t = -32768;
                    r[16*k +: 16] = t[15:0];
                end
            end
            OP_ADDUSB: begin
                for (int i = 0; i < 16; i++) begin
                    t = int'(a[8*i +: 8]) + int'(b[8*i +: 8]);
                    r[8*i +: 8] = (t > 255) ? 8'hFF : t[7:0];
                end
            end
            OP_CMPEQB: begin
                for (int i = 0; i < 16; i++)
                    r[8*i +: 8] = (a[8*i +: 8] == b[8*i +: 8]) ? 8'hFF : 8'h00;
            end
            OP_CMPGTW: begin
                for (int k = 0; k < 8; k++) begin
                    x = $signed(a[16*k +: 16]);
                    y = $signed(b[16*k +: 16]);
                    r[16*k +: 16] = (x > y) ? 16'hFFFF : 16'h0000;
                end
            end
            OP_EXTRACTW: sc = a[16*imm[2:0] +: 16];   // index wraps at eight
            OP_MAXSW: begin
                for (int k = 0; k < 8; k++) begin
                    x = $signed(a[16*k +: 16]);
                    y = $signed(b[16*k +: 16]);
                    r[16*k +: 16] = (x > y) ? a[16*k +: 16] : b[16*k +: 16];
                end
            end
            OP_MAXUB: begin
                for (int i = 0; i < 16; i++)
                    r[8*i +: 8] = (a[8*i +: 8] > b[8*i +: 8]) ? a[8*i +: 8] : b[8*i +: 8];
            end
            OP_MOVEMASK: begin
                for (int i = 0; i < 16; i++)
                    sc[i] = a[8*i + 7];
            end
            OP_SET1W: r = {8{s[15:0]}};
            OP_SET1D: r = {4{s}};
            OP_SET1B: r = {16{s[7:0]}};
            OP_SHLB:  if (imm < 16) r = a << (8 * imm);   // past 15 bytes: all zero
            OP_SHRB:  if (imm < 16) r = a >> (8 * imm);
            OP_SUBUSW: begin
                for (int k = 0; k < 8; k++) begin
                    x = a[16*k +: 16];
                    y = b[16*k +: 16];
                    t = (x < y) ? 0 : x - y;
                    r[16*k +: 16] = t[15:0];
                end
            end
            OP_SUBUSB: begin
                for (int i = 0; i < 16; i++) begin
                    x = a[8*i +: 8];
                    y = b[8*i +: 8];
                    t = (x < y) ? 0 : x - y;
                    r[8*i +: 8] = t[7:0];
                end
            end
            default: ;   // unused opcode: everything zero
        endcase
        res.r_low  = r[63:0];
        res.r_high = r[127:64];
        res.sc     = sc;
        return res;
    endfunction

    // Operand with a bias toward lane corners: saturation edges, sign flips.
    function automatic logic [C_VEC_W-1:0] pick_operand();
        logic [C_VEC_W-1:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 3))
            2: begin
                for (int k = 0; k < 8; k++) begin
                    case ($urandom_range(0, 6))
                        0: v[16*k +: 16] = 16'h0000;
                        1: v[16*k +: 16] = 16'h0001;
                        2: v[16*k +: 16] = 16'h7FFF;
                        3: v[16*k +: 16] = 16'h8000;
                        4: v[16*k +: 16] = 16'hFFFF;
                        5: v[16*k +: 16] = 16'h7F80;
                        default: ;
                    endcase
                end
            end
            3: begin
                for (int i = 0; i < 16; i++) begin
                    case ($urandom_range(0, 5))
                        0: v[8*i +: 8] = 8'h00;
                        1: v[8*i +: 8] = 8'h01;
                        2: v[8*i +: 8] = 8'h7F;
                        3: v[8*i +: 8] = 8'h80;
                        4: v[8*i +: 8] = 8'hFF;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_row(input logic [C_OP_W-1:0] op, input logic [C_VEC_W-1:0] a,
                           input logic [C_VEC_W-1:0] b, input logic [C_IMM_W-1:0] imm,
                           input logic [C_SCIN_W-1:0] s, input bit fixed,
                           input logic [C_VEC_W-1:0] r, input logic [C_SCOUT_W-1:0] sc);
        t_op_row row;
        row.op            = op;
        row.a             = a;
        row.b             = b;
        row.imm           = imm;
        row.s             = s;
        row.fixed         = fixed;
        row.answer.r_low  = r[63:0];
        row.answer.r_high = r[127:64];
        row.answer.sc     = sc;
        directed_rows.push_back(row);
    endtask

    // Present one item at the falling edge and hold it until accepted.
    task automatic issue(input logic [C_OP_W-1:0] op, input logic [C_VEC_W-1:0] a,
                         input logic [C_VEC_W-1:0] b, input logic [C_IMM_W-1:0] imm,
                         input logic [C_SCIN_W-1:0] s, input bit fixed,
                         input t_lane_result answer);
        @(negedge i_clk);
        start       <= 1'b1;
        i_op        <= op;
        i_a_low     <= a[63:0];
        i_a_high    <= a[127:64];
        i_b_low     <= b[63:0];
        i_b_high    <= b[127:64];
        i_imm       <= imm;
        i_scalar_in <= s;
        row_fixed    = fixed;
        row_answer   = answer;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Sender gaps: each cycle idles with the given chance in a hundred.
    task automatic idle_gap(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off until every queued result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] got_v);
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
        mismatch_count++;
    endtask

    // Scoreboard: pop on strobe first, then queue the item accepted at this
    // edge. Both happen on pre-edge values, so order within the step is moot.
    always @(posedge i_clk) begin
        t_lane_result want;
        if (o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, got %h %h %h",
                         $time, o_r_high, o_r_low, o_scalar_out);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_r_low !== want.r_low)
                    report_field("r_low", want.r_low, o_r_low);
                if (o_r_high !== want.r_high)
                    report_field("r_high", want.r_high, o_r_high);
                if (o_scalar_out !== want.sc)
                    report_field("scalar_out", 64'(want.sc), 64'(o_scalar_out));
            end
        end
        if (start === 1'b1 && busy === 1'b0) begin
            if (row_fixed)
                pending_results.push_back(row_answer);
            else
                pending_results.push_back(simd_result(i_op, {i_a_high, i_a_low},
                                                      {i_b_high, i_b_low}, i_imm,
                                                      i_scalar_in));
        end
    end

    // Stimulus
    initial begin
        logic [C_VEC_W-1:0] a;
        logic [C_VEC_W-1:0] b;
        logic [C_VEC_W-1:0] ramp;
        logic [C_IMM_W-1:0] imm;
        int                 idle_pct;
        int                 pos;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = '0;
        i_a_low     = '0;
        i_a_high    = '0;
        i_b_low     = '0;
        i_b_high    = '0;
        i_imm       = '0;
        i_scalar_in = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed rows: corners of each op, typed answers where obvious
        ramp = 128'h8888_7777_6666_5555_4444_3333_2222_1111;
        add_row(OP_ADDSW, {8{16'h7FFF}}, {8{16'h0001}}, 0, 0, 1, {8{16'h7FFF}}, 0);
        add_row(OP_ADDSW, {8{16'h8000}}, {8{16'hFFFF}}, 0, 0, 1, {8{16'h8000}}, 0);
        add_row(OP_ADDSW, pick_operand(), pick_operand(), 0, 0, 0, 0, 0);
        add_row(OP_ADDUSB, {16{8'hFF}}, {16{8'h01}}, 0, 0, 1, {16{8'hFF}}, 0);
        add_row(OP_ADDUSB, '0, '0, 0, 0, 1, '0, 0);
        add_row(OP_CMPEQB, ramp, ramp, 0, 0, 1, {128{1'b1}}, 0);
        add_row(OP_CMPEQB, ramp, ramp ^ 128'h1, 0, 0, 0, 0, 0);
        add_row(OP_CMPGTW, '0, {8{16'h8000}}, 0, 0, 1, {128{1'b1}}, 0);
        add_row(OP_CMPGTW, {8{16'h8000}}, {8{16'h7FFF}}, 0, 0, 1, '0, 0);
        // lane index wraps: 9 picks lane 1, 31 picks lane 7
        add_row(OP_EXTRACTW, ramp, '1, 9, 0, 1, '0, 16'h2222);
        add_row(OP_EXTRACTW, ramp, '1, 31, 0, 1, '0, 16'h8888);
        add_row(OP_MAXSW, {8{16'h8000}}, {8{16'h7FFF}}, 0, 0, 1, {8{16'h7FFF}}, 0);
        add_row(OP_MAXUB, {16{8'h80}}, {16{8'h7F}}, 0, 0, 1, {16{8'h80}}, 0);
        add_row(OP_MOVEMASK, {16{8'h80}}, '0, 0, 0, 1, '0, 16'hFFFF);
        add_row(OP_MOVEMASK, pick_operand(), pick_operand(), 0, 0, 0, 0, 0);
        add_row(OP_SET1W, '1, '1, 31, 32'hDEADBEEF, 1, {8{16'hBEEF}}, 0);
        add_row(OP_SET1D, '0, '0, 0, 32'hDEADBEEF, 1, {4{32'hDEADBEEF}}, 0);
        add_row(OP_SET1B, '0, '0, 0, 32'h123456AB, 1, {16{8'hAB}}, 0);
        add_row(OP_SHLB, ramp, '1, 0, 0, 1, ramp, 0);
        add_row(OP_SHLB, ramp, '0, 16, 0, 1, '0, 0);
        add_row(OP_SHLB, pick_operand(), '0, 5, 0, 0, 0, 0);
        add_row(OP_SHRB, pick_operand(), '0, 15, 0, 0, 0, 0);
        add_row(OP_SHRB, '1, '0, 31, 0, 1, '0, 0);
        add_row(OP_SUBUSW, '0, {8{16'h0001}}, 0, 0, 1, '0, 0);
        add_row(OP_SUBUSB, {16{8'h10}}, {16{8'h20}}, 0, 0, 1, '0, 0);
        add_row(OP_UNUSED, '1, '1, 31, '1, 1, '0, 0);

        foreach (directed_rows[n])
            issue(directed_rows[n].op, directed_rows[n].a, directed_rows[n].b,
                  directed_rows[n].imm, directed_rows[n].s, directed_rows[n].fixed,
                  directed_rows[n].answer);
        drain_results();

        // --- random items in three phases: light gaps, heavy gaps, none
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 37 : (phase == 1) ? 88 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                a = pick_operand();
                b = pick_operand();
                // about a quarter of the time b tracks a: equal lanes matter
                // for compare, max and saturating subtract
                if ($urandom_range(0, 3) == 0) begin
                    b = a;
                    repeat ($urandom_range(0, 3)) begin
                        pos = $urandom_range(0, 15);
                        b[8*pos +: 8] = 8'($urandom);
                    end
                end
                imm = ($urandom_range(0, 3) == 0) ? C_IMM_W'($urandom_range(0, 31))
                                                  : C_IMM_W'($urandom_range(0, 16));
                idle_gap(idle_pct);
                issue(C_OP_W'($urandom_range(0, 15)), a, b, imm, $urandom, 1'b0, '0);
                if ($urandom_range(0, 59) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: a hung handshake or a lost result lands here.
    initial begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
